// ----- sv/assert_macros.svh -----
// Assertion macros used by the top level of the integer ALU.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ----- sv/tia_pkg.sv -----
// Package for the typed integer ALU: opcodes, kinds, payload structs,
// and the per-stage record passed along the cell chain. No dependencies.
package tia_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned BitsPerCell = 1;
    localparam int unsigned NumCells = DataWidth / BitsPerCell;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_MOD = 4'd4, OP_AND = 4'd5, OP_OR = 4'd6, OP_XOR = 4'd7,
        OP_SHL = 4'd8, OP_SHR = 4'd9, OP_EQ = 4'd10, OP_NE = 4'd11,
        OP_LT = 4'd12, OP_LE = 4'd13, OP_GT = 4'd14, OP_GE = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        KIND_S32 = 2'd0, KIND_U32 = 2'd1, KIND_S64 = 2'd2, KIND_U64 = 2'd3
    } kind_t;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [1:0]  data_kind;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } req_t;

    typedef struct packed {
        logic [63:0] value;
        logic        ok;
        logic        is_compare;
    } rsp_t;

    // Record carried between cells: a restoring-divide step per cell, or
    // a shift-add multiply step (rem is the accumulator, quo the multiplier
    // bits taken MSB first, divisor the multiplicand).
    // rem/quo hold partial remainder and quotient (dividend bits shift
    // out of quo as quotient bits shift in). res carries the fast result.
    typedef struct packed {
        logic        valid;
        logic        is_div;
        logic        is_mod;
        logic        is_mul;
        logic        neg_q;
        logic        neg_r;
        logic        wide;
        logic [63:0] divisor;
        logic [63:0] rem;
        logic [63:0] quo;
        rsp_t        res;
    } stage_t;

endpackage

// ----- sv/typed_integer_alu.sv -----
// Top level of the typed integer ALU: front decode stage, a chain of
// divide/multiply cells, and an output register. Depends on tia_pkg,
// tia_front, tia_cell and assert_macros.svh.
//
//  channel | direction | ports
//  request | in        | s_valid, s_ready, s_data (tia_pkg::req_t)
//  result  | out       | m_valid, m_ready, m_data (tia_pkg::rsp_t)
//
// One transaction per cycle is accepted while the output is not stalled. The
// depth is set by the chain, one quotient or multiplier bit per cell. The whole
// pipeline advances together and freezes when the output register holds a
// result that is not taken. Reset clears all valid bits.
`include "assert_macros.svh"
module typed_integer_alu (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tia_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tia_pkg::rsp_t m_data
);
    tia_pkg::stage_t chain [tia_pkg::NumCells+1];
    tia_pkg::stage_t last;
    tia_pkg::rsp_t   fin;
    logic            adv;
    logic            m_valid_reg;
    tia_pkg::rsp_t   m_data_reg;
    logic [63:0]     q, rm, pr;

    assign adv = !m_valid_reg || m_ready;
    assign s_ready = adv;

    tia_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .in_valid(s_valid), .req(s_data), .out_reg(chain[0])
    );

    for (genvar i = 0; i < tia_pkg::NumCells; i++) begin : g_cell
        tia_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_stage(chain[i]), .out_reg(chain[i+1])
        );
    end

    assign last = chain[tia_pkg::NumCells];

    always_comb begin
        q = last.neg_q ? (64'd0 - last.quo) : last.quo;
        rm = last.neg_r ? (64'd0 - last.rem) : last.rem;
        pr = last.rem;
        if (!last.wide) begin
            q = {32'd0, q[31:0]};
            rm = {32'd0, rm[31:0]};
            pr = {32'd0, pr[31:0]};
        end
        fin = last.res;
        if (last.is_mul) begin
            fin.value = pr;
        end else if (last.is_div) begin
            fin.value = q;
        end else if (last.is_mod) begin
            fin.value = rm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= last.valid;
            m_data_reg <= fin;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    `ASSERT_CLK(a_ready_when_empty, aclk, aresetn, !m_valid_reg |-> s_ready, "ready low with empty output")
    `ASSERT_CLK(a_hold_on_stall, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_data), "output changed under stall")
    `ASSERT_CLK(a_cmp_bool, aclk, aresetn, (m_valid && m_data.is_compare) |-> (m_data.value[63:1] == 63'd0), "compare not boolean")
    `ASSERT_CLK(a_bad_div_cmp, aclk, aresetn, (m_valid && !m_data.ok) |-> !m_data.is_compare, "error on compare")
endmodule

// ----- sv/tia_front.sv -----
// Front stage of the integer ALU: decodes the transaction, computes all
// operations but multiply, divide and modulo, and prepares operands for the
// divide/multiply chain. Depends on tia_pkg.
module tia_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  tia_pkg::req_t  req,
    output tia_pkg::stage_t out_reg
);
    logic        is_signed;
    logic        wide;
    logic [63:0] mask;
    logic [63:0] a, b, sa, sb, ka, kb, ma, mb, r;
    logic [5:0]  sh;
    logic        na, nb, isdiv, ismod, ismul, cmp;
    tia_pkg::stage_t out_next;

    always_comb begin
        is_signed = (req.data_kind == tia_pkg::KIND_S32) || (req.data_kind == tia_pkg::KIND_S64);
        wide = req.data_kind[1];
        mask = wide ? {64{1'b1}} : {32'd0, {32{1'b1}}};
        a = req.operand_a & mask;
        b = req.operand_b & mask;
        sa = (is_signed && !wide) ? {{32{a[31]}}, a[31:0]} : a;
        sb = (is_signed && !wide) ? {{32{b[31]}}, b[31:0]} : b;
        sh = wide ? b[5:0] : {1'b0, b[4:0]};
        na = is_signed && sa[63];
        nb = is_signed && sb[63];
        ma = na ? (64'd0 - sa) : sa;
        mb = nb ? (64'd0 - sb) : sb;
        ka = is_signed ? (sa ^ 64'h8000_0000_0000_0000) : a;
        kb = is_signed ? (sb ^ 64'h8000_0000_0000_0000) : b;
        isdiv = 1'b0;
        ismod = 1'b0;
        ismul = 1'b0;
        cmp = 1'b0;
        r = '0;
        case (tia_pkg::op_t'(req.req_type))
            tia_pkg::OP_ADD: r = a + b;
            tia_pkg::OP_SUB: r = a - b;
            tia_pkg::OP_MUL: ismul = 1'b1;
            tia_pkg::OP_DIV: isdiv = 1'b1;
            tia_pkg::OP_MOD: ismod = 1'b1;
            tia_pkg::OP_AND: r = a & b;
            tia_pkg::OP_OR:  r = a | b;
            tia_pkg::OP_XOR: r = a ^ b;
            tia_pkg::OP_SHL: r = a << sh;
            tia_pkg::OP_SHR: r = (is_signed && sa[63]) ? ~((~sa) >> sh) : (a >> sh);
            tia_pkg::OP_EQ: begin cmp = 1'b1; r = {63'd0, ka == kb}; end
            tia_pkg::OP_NE: begin cmp = 1'b1; r = {63'd0, ka != kb}; end
            tia_pkg::OP_LT: begin cmp = 1'b1; r = {63'd0, ka < kb}; end
            tia_pkg::OP_LE: begin cmp = 1'b1; r = {63'd0, ka <= kb}; end
            tia_pkg::OP_GT: begin cmp = 1'b1; r = {63'd0, ka > kb}; end
            default:        begin cmp = 1'b1; r = {63'd0, ka >= kb}; end
        endcase
        if (!cmp) begin
            r = r & mask;
        end
        out_next.valid = in_valid;
        out_next.is_div = isdiv && (b != 64'd0);
        out_next.is_mod = ismod && (b != 64'd0);
        out_next.is_mul = ismul;
        out_next.neg_q = na ^ nb;
        out_next.neg_r = na;
        out_next.wide = wide;
        out_next.divisor = ismul ? a : mb;
        out_next.rem = '0;
        out_next.quo = ismul ? b : ma;
        out_next.res.value = r;
        out_next.res.ok = !((isdiv || ismod) && (b == 64'd0));
        out_next.res.is_compare = cmp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end
endmodule

// ----- sv/tia_cell.sv -----
// One cell of the divide/multiply chain: a single restoring-division step
// or a single shift-add multiply step on the record it receives, registered
// toward the next cell. Depends on tia_pkg.
module tia_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  tia_pkg::stage_t in_stage,
    output tia_pkg::stage_t out_reg
);
    tia_pkg::stage_t out_next;
    logic [64:0] trial;
    logic [64:0] diff;
    logic [63:0] acc;

    always_comb begin
        out_next = in_stage;
        trial = {in_stage.rem, in_stage.quo[63]};
        diff = trial - {1'b0, in_stage.divisor};
        acc = {in_stage.rem[62:0], 1'b0} + (in_stage.quo[63] ? in_stage.divisor : 64'd0);
        if (in_stage.is_mul) begin
            out_next.rem = acc;
            out_next.quo = {in_stage.quo[62:0], 1'b0};
        end else if (!diff[64]) begin
            out_next.rem = diff[63:0];
            out_next.quo = {in_stage.quo[62:0], 1'b1};
        end else begin
            out_next.rem = trial[63:0];
            out_next.quo = {in_stage.quo[62:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end
endmodule
